// ===== hdl/slps_pkg.sv =====
// Shared types and constants for the status LED pattern sequencer.
// Depends on nothing; every other file in hdl/ uses it.
package slps_pkg;

    // Display mode codes
    localparam logic [2:0] MODE_IDLE         = 3'd0;
    localparam logic [2:0] MODE_CONFIG_END   = 3'd1;
    localparam logic [2:0] MODE_CONFIGURING  = 3'd2;
    localparam logic [2:0] MODE_CHECK_CONFIG = 3'd3;
    localparam logic [2:0] MODE_DISCONNECT   = 3'd4;

    // Command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET_MODE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_BLINK_PERIOD = 2'd0;
    localparam logic [1:0] REG_TRIP_HOLD    = 2'd1;
    localparam logic [1:0] REG_TOGGLE_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [15:0] BLINK_PERIOD_RST = 16'd100;
    localparam logic [15:0] TRIP_HOLD_RST    = 16'd500;
    localparam logic [3:0]  TOGGLE_LIMIT_RST = 4'd6;

    typedef struct packed {
        logic [15:0] blink_period;
        logic [15:0] trip_hold;
        logic [3:0]  toggle_limit;
    } cfg_t;

    typedef struct packed {
        logic       command;
        logic [2:0] new_mode;
        logic       low_voltage;
        logic       thermal;
        logic       ocd_trigger;
        logic       ocd_trip_set;
    } item_t;

    typedef struct packed {
        logic       green_on;
        logic       red_on;
        logic       trip_latched;
        logic [2:0] mode_now;
    } result_t;

endpackage

// ===== hdl/status_led_pattern_sequencer.sv =====
// Top level of the status LED pattern sequencer: input register, state
// update and result register. Depends on slps_pkg, slps_cfg_regs, slps_core.
//
//  channel | signals                                   | flow
//  --------+-------------------------------------------+-------------------
//  in      | in_valid, in_stall, command..ocd_trip_set | valid / stall
//  out     | out_valid, out_stall, green_on..mode_now  | valid / stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | valid / ready
//
// One item per cycle sustained while out_stall stays low; each result passes
// through the input register and then the result register before it is on
// the outputs, where it can transfer.
// The state update sits between the two registers.
// Reset (rst_n low) empties both registers and loads the default settings.
// A stalled output holds its result; the input register keeps taking items
// until it too is full, and then in_stall rises.
module status_led_pattern_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [2:0]  new_mode,
    input  logic        low_voltage,
    input  logic        thermal,
    input  logic        ocd_trigger,
    input  logic        ocd_trip_set,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        green_on,
    output logic        red_on,
    output logic        trip_latched,
    output logic [2:0]  mode_now,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    slps_pkg::cfg_t    cfg;
    slps_pkg::item_t   item_reg;
    slps_pkg::result_t result_next;
    slps_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              adv_out;
    logic              adv_in;
    logic              fire;

    // Pipeline advance
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign fire     = in_valid_reg && adv_out;
    assign in_stall = !adv_in;

    slps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slps_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (adv_in)
            in_valid_reg <= in_valid;
    end

    // Capture the item on each input transfer
    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            item_reg.command      <= command;
            item_reg.new_mode     <= new_mode;
            item_reg.low_voltage  <= low_voltage;
            item_reg.thermal      <= thermal;
            item_reg.ocd_trigger  <= ocd_trigger;
            item_reg.ocd_trip_set <= ocd_trip_set;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_out)
            out_valid_reg <= in_valid_reg;
    end

    // Load the result when the item leaves the input register
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign green_on     = result_reg.green_on;
    assign red_on       = result_reg.red_on;
    assign trip_latched = result_reg.trip_latched;
    assign mode_now     = result_reg.mode_now;

endmodule

// ===== hdl/slps_cfg_regs.sv =====
// Configuration register file: blink period, trip hold, toggle limit.
// Depends on slps_pkg.
module slps_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output slps_pkg::cfg_t     cfg
);

    slps_pkg::cfg_t cfg_reg;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Store a register on each write transfer; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_period <= slps_pkg::BLINK_PERIOD_RST;
            cfg_reg.trip_hold    <= slps_pkg::TRIP_HOLD_RST;
            cfg_reg.toggle_limit <= slps_pkg::TOGGLE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slps_pkg::REG_BLINK_PERIOD: cfg_reg.blink_period <= cfg_data;
                slps_pkg::REG_TRIP_HOLD:    cfg_reg.trip_hold    <= cfg_data;
                slps_pkg::REG_TOGGLE_LIMIT: cfg_reg.toggle_limit <= cfg_data[3:0];
                default:                    ;
            endcase
        end
    end

endmodule

// ===== hdl/slps_core.sv =====
// Sequencer state and next-state logic; computes the result of one item.
// Depends on slps_pkg.
module slps_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  slps_pkg::item_t     item,
    input  slps_pkg::cfg_t      cfg,
    output slps_pkg::result_t   result_next
);

    logic [2:0]  mode_reg,  mode_next;
    logic [15:0] pc_reg,    pc_next;
    logic [3:0]  tc_reg,    tc_next;
    logic        green_reg, green_next;
    logic        red_reg,   red_next;
    logic        trip_reg,  trip_next;

    logic        trip_v;
    logic        elapsed;
    logic [15:0] pc_inc;
    logic [3:0]  tc_inc;

    assign trip_v  = trip_reg | item.ocd_trip_set;
    assign elapsed = (pc_reg >= cfg.blink_period);
    assign pc_inc  = pc_reg + 16'd1;
    assign tc_inc  = tc_reg + 4'd1;

    // Work out the state after this item, in pattern priority order
    always_comb
    begin
        mode_next  = mode_reg;
        pc_next    = pc_reg;
        tc_next    = tc_reg;
        green_next = green_reg;
        red_next   = red_reg;
        trip_next  = trip_reg;
        if (item.command == slps_pkg::CMD_SET_MODE)
        begin
            mode_next = (item.new_mode <= slps_pkg::MODE_DISCONNECT)
                        ? item.new_mode : slps_pkg::MODE_IDLE;
        end
        else
        begin
            trip_next = trip_v;
            priority if (mode_reg == slps_pkg::MODE_CONFIG_END)
            begin
                if (tc_reg < cfg.toggle_limit)
                begin
                    if (elapsed)
                    begin
                        pc_next    = '0;
                        green_next = !green_reg;
                        tc_next    = tc_inc;
                    end
                    else
                        pc_next = pc_inc;
                end
                else
                begin
                    tc_next   = '0;
                    pc_next   = '0;
                    mode_next = slps_pkg::MODE_IDLE;
                end
            end
            else if (mode_reg == slps_pkg::MODE_CONFIGURING)
            begin
                if (elapsed)
                begin
                    pc_next    = '0;
                    green_next = !green_reg;
                end
                else
                    pc_next = pc_inc;
            end
            else if (trip_v)
            begin
                // Hold LEDs off while the trigger lasts, then release the latch
                if (item.ocd_trigger)
                begin
                    pc_next    = '0;
                    green_next = 1'b0;
                    red_next   = 1'b0;
                end
                else if (pc_reg >= cfg.trip_hold)
                    trip_next = 1'b0;
                else
                    pc_next = pc_inc;
            end
            else if (item.low_voltage)
                red_next = 1'b1;
            else if (item.thermal)
            begin
                if (elapsed)
                begin
                    pc_next  = '0;
                    red_next = !red_reg;
                end
                else
                    pc_next = pc_inc;
            end
            else if (mode_reg == slps_pkg::MODE_CHECK_CONFIG)
            begin
                if (elapsed)
                begin
                    pc_next   = '0;
                    mode_next = slps_pkg::MODE_IDLE;
                end
                else
                begin
                    pc_next    = pc_inc;
                    green_next = 1'b0;
                    red_next   = 1'b0;
                end
            end
            else if (mode_reg == slps_pkg::MODE_DISCONNECT)
            begin
                if (elapsed)
                begin
                    pc_next  = '0;
                    red_next = !red_reg;
                    if (tc_inc >= cfg.toggle_limit)
                    begin
                        tc_next   = '0;
                        mode_next = slps_pkg::MODE_IDLE;
                    end
                    else
                        tc_next = tc_inc;
                end
                else
                    pc_next = pc_inc;
            end
            else
            begin
                green_next = 1'b1;
                tc_next    = '0;
                pc_next    = '0;
            end
        end
    end

    assign result_next.green_on     = green_next;
    assign result_next.red_on       = red_next;
    assign result_next.trip_latched = trip_next;
    assign result_next.mode_now     = mode_next;

    // Commit the new state when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slps_pkg::MODE_IDLE;
            pc_reg    <= '0;
            tc_reg    <= '0;
            green_reg <= 1'b0;
            red_reg   <= 1'b0;
            trip_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            pc_reg    <= pc_next;
            tc_reg    <= tc_next;
            green_reg <= green_next;
            red_reg   <= red_next;
            trip_reg  <= trip_next;
        end
    end

    // Set-mode items leave counters and LEDs untouched
    a_setmode_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.command == slps_pkg::CMD_SET_MODE |=>
        pc_reg == $past(pc_reg) && tc_reg == $past(tc_reg)
        && green_reg == $past(green_reg) && red_reg == $past(red_reg))
        else $error("set-mode item changed counters or LEDs");

    // State moves only with an item
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(mode_reg) && $stable(pc_reg) && $stable(tc_reg)
        && $stable(trip_reg))
        else $error("state changed without an item");

    // Trip latch sets only from a tick that carries the set flag
    a_trip_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(trip_reg) |-> $past(fire && item.ocd_trip_set
        && item.command == slps_pkg::CMD_TICK))
        else $error("trip latch set without a trip-set tick");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for status_led_pattern_sequencer: a queued driver and a
// checking monitor, with an item-by-item LED sequence predictor alongside.
// Depends on slps_pkg and the RTL of the block only.
module tb;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = slps_pkg::CMD_TICK;
    logic [2:0]  new_mode = slps_pkg::MODE_IDLE;
    logic        low_voltage = 1'b0;
    logic        thermal = 1'b0;
    logic        ocd_trigger = 1'b0;
    logic        ocd_trip_set = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        green_on;
    logic        red_on;
    logic        trip_latched;
    logic [2:0]  mode_now;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = slps_pkg::REG_BLINK_PERIOD;
    logic [15:0] cfg_data = 16'd0;

    status_led_pattern_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .new_mode     (new_mode),
        .low_voltage  (low_voltage),
        .thermal      (thermal),
        .ocd_trigger  (ocd_trigger),
        .ocd_trip_set (ocd_trip_set),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .green_on     (green_on),
        .red_on       (red_on),
        .trip_latched (trip_latched),
        .mode_now     (mode_now),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    slps_pkg::item_t   pending_items[$];
    slps_pkg::result_t expected_leds[$];
    int      error_count = 0;
    int      items_sent = 0;
    int      results_checked = 0;
    int      settings_applied = 0;
    int      cycle_count = 0;
    bit      sender_gaps_on = 1'b1;
    bit      receiver_gaps_on = 1'b1;
    bit      receiver_hold = 1'b0;
    bit      long_hold_go = 1'b0;

    // Shadow of the block's settings and sequencer state
    slps_pkg::cfg_t shadow_cfg = '{slps_pkg::BLINK_PERIOD_RST, slps_pkg::TRIP_HOLD_RST,
                                   slps_pkg::TOGGLE_LIMIT_RST};
    logic [2:0]  seq_mode = slps_pkg::MODE_IDLE;
    logic [15:0] seq_period = 16'd0;
    logic [3:0]  seq_toggles = 4'd0;
    logic        seq_green = 1'b0;
    logic        seq_red = 1'b0;
    logic        seq_trip = 1'b0;

    // Restart the period counter when it reaches the blink period, else count up
    function automatic bit period_rollover();
        if (seq_period >= shadow_cfg.blink_period)
        begin
            seq_period = 16'd0;
            return 1'b1;
        end
        seq_period = seq_period + 16'd1;
        return 1'b0;
    endfunction

    // Advance the LED sequencer by one item and return the LED levels it shows
    function automatic slps_pkg::result_t led_sequence_step(slps_pkg::item_t it);
        slps_pkg::result_t r;
        if (it.command == slps_pkg::CMD_SET_MODE)
        begin
            seq_mode = (it.new_mode <= slps_pkg::MODE_DISCONNECT) ? it.new_mode
                                                                  : slps_pkg::MODE_IDLE;
        end
        else
        begin
            if (it.ocd_trip_set)
                seq_trip = 1'b1;
            if (seq_mode == slps_pkg::MODE_CONFIG_END)
            begin
                if (seq_toggles < shadow_cfg.toggle_limit)
                begin
                    if (period_rollover())
                    begin
                        seq_green = ~seq_green;
                        seq_toggles = seq_toggles + 4'd1;
                    end
                end
                else
                begin
                    seq_toggles = 4'd0;
                    seq_period = 16'd0;
                    seq_mode = slps_pkg::MODE_IDLE;
                end
            end
            else if (seq_mode == slps_pkg::MODE_CONFIGURING)
            begin
                if (period_rollover())
                    seq_green = ~seq_green;
            end
            else if (seq_trip)
            begin
                if (it.ocd_trigger)
                begin
                    seq_period = 16'd0;
                    seq_green = 1'b0;
                    seq_red = 1'b0;
                end
                else if (seq_period >= shadow_cfg.trip_hold)
                begin
                    seq_trip = 1'b0;
                end
                else
                begin
                    seq_period = seq_period + 16'd1;
                end
            end
            else if (it.low_voltage)
            begin
                seq_red = 1'b1;
            end
            else if (it.thermal)
            begin
                if (period_rollover())
                    seq_red = ~seq_red;
            end
            else if (seq_mode == slps_pkg::MODE_CHECK_CONFIG)
            begin
                if (seq_period >= shadow_cfg.blink_period)
                begin
                    seq_period = 16'd0;
                    seq_mode = slps_pkg::MODE_IDLE;
                end
                else
                begin
                    seq_period = seq_period + 16'd1;
                    seq_green = 1'b0;
                    seq_red = 1'b0;
                end
            end
            else if (seq_mode == slps_pkg::MODE_DISCONNECT)
            begin
                if (period_rollover())
                begin
                    seq_red = ~seq_red;
                    seq_toggles = seq_toggles + 4'd1;
                    if (seq_toggles >= shadow_cfg.toggle_limit)
                    begin
                        seq_toggles = 4'd0;
                        seq_mode = slps_pkg::MODE_IDLE;
                    end
                end
            end
            else
            begin
                seq_green = 1'b1;
                seq_toggles = 4'd0;
                seq_period = 16'd0;
            end
        end
        r.green_on = seq_green;
        r.red_on = seq_red;
        r.trip_latched = seq_trip;
        r.mode_now = seq_mode;
        return r;
    endfunction

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Driver: offer queued items, hold each one until its transfer
    always @(posedge clk or negedge rst_n)
    begin : driver
        slps_pkg::item_t offered;
        int              send_gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_leds.push_back(led_sequence_step(offered));
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    offered = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    command      <= offered.command;
                    new_mode     <= offered.new_mode;
                    low_voltage  <= offered.low_voltage;
                    thermal      <= offered.thermal;
                    ocd_trigger  <= offered.ocd_trigger;
                    ocd_trip_set <= offered.ocd_trip_set;
                    send_gap = (sender_gaps_on && $urandom_range(0, 2) == 0) ?
                               pick_idle_len() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer, then decide the next stall
    always @(posedge clk or negedge rst_n)
    begin : monitor
        slps_pkg::result_t want;
        int                stall_left;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_leds.size() == 0)
                begin
                    $error("result with nothing expected: green_on=%0b red_on=%0b %s",
                           green_on, red_on,
                           $sformatf("trip=%0b mode=%0d", trip_latched, mode_now));
                    error_count++;
                end
                else
                begin
                    want = expected_leds.pop_front();
                    if (green_on !== want.green_on)
                    begin
                        $error("green_on: expected %0b, actual %0b", want.green_on, green_on);
                        error_count++;
                    end
                    if (red_on !== want.red_on)
                    begin
                        $error("red_on: expected %0b, actual %0b", want.red_on, red_on);
                        error_count++;
                    end
                    if (trip_latched !== want.trip_latched)
                    begin
                        $error("trip_latched: expected %0b, actual %0b",
                               want.trip_latched, trip_latched);
                        error_count++;
                    end
                    if (mode_now !== want.mode_now)
                    begin
                        $error("mode_now: expected %0d, actual %0d", want.mode_now, mode_now);
                        error_count++;
                    end
                    results_checked++;
                end
            end
            if (receiver_hold)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (receiver_gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = pick_idle_len();
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Long output hold-off so the block fills and pushes back on its input
    initial
    begin
        wait (long_hold_go);
        @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (120) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status_led_pattern_sequencer: mismatch");
            $finish;
        end
    end

    task automatic queue_item(input logic cmd, input logic [2:0] m, input logic lv,
                              input logic th, input logic trig, input logic trip);
        slps_pkg::item_t it;
        it.command = cmd;
        it.new_mode = m;
        it.low_voltage = lv;
        it.thermal = th;
        it.ocd_trigger = trig;
        it.ocd_trip_set = trip;
        pending_items.push_back(it);
    endtask

    // Ticks with mostly quiet protection flags; new_mode is ignored on ticks
    task automatic queue_quiet_tick();
        queue_item(slps_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 19) == 0);
    endtask

    // Mode changes followed by runs of ticks, trip episodes, and some noise
    task automatic queue_random_traffic(input int n);
        int         left;
        int         pick;
        int         run;
        int         release_run;
        logic [7:0] raw;
        left = n;
        while (left > 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                queue_item(slps_pkg::CMD_SET_MODE, 3'($urandom_range(0, 4)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                run = $urandom_range(1, 16);
                repeat (run) queue_quiet_tick();
                left -= run + 1;
            end
            else if (pick < 8)
            begin
                // latch a trip, keep the trigger for a while, then let it clear
                queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0,
                           1'($urandom_range(0, 1)), 1'b1);
                run = $urandom_range(0, 4);
                repeat (run)
                    queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0);
                release_run = $urandom_range(1, 8);
                repeat (release_run)
                    queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE,
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'b0, 1'b0);
                left -= run + release_run + 1;
            end
            else
            begin
                raw = 8'($urandom_range(0, 255));
                pending_items.push_back(slps_pkg::item_t'(raw));
                left--;
            end
        end
    endtask

    // Write one register and update the shadow copy at its transfer
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            slps_pkg::REG_BLINK_PERIOD: shadow_cfg.blink_period = val;
            slps_pkg::REG_TRIP_HOLD:    shadow_cfg.trip_hold = val;
            slps_pkg::REG_TOGGLE_LIMIT: shadow_cfg.toggle_limit = val[3:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] period, input logic [15:0] hold,
                                  input logic [3:0] limit, input bit gaps);
        write_reg(slps_pkg::REG_BLINK_PERIOD, period);
        write_reg(slps_pkg::REG_TRIP_HOLD, hold);
        write_reg(slps_pkg::REG_TOGGLE_LIMIT, {12'd0, limit});
        settings_applied++;
        sender_gaps_on <= gaps;
        receiver_gaps_on <= gaps;
    endtask

    // Wait until every item is sent and every result is back, then let it settle;
    // sample between edges so the driver's updates for the edge are in place
    task automatic settle();
        do @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_leds.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed pass on reset settings: every mode, unknown modes, each flag
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CONFIG_END, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CONFIGURING, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, 3'd7, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, 3'd5, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, 3'd6, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, 3'd7, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CHECK_CONFIG, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_DISCONNECT, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b1);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CONFIGURING, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b1);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        settle();

        // Zero periods and zero toggle limit: immediate exits and per-tick blinks
        apply_settings(16'd0, 16'd0, 4'd0, 1'b1);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CONFIG_END, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_DISCONNECT, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b1);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CONFIGURING, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_SET_MODE, slps_pkg::MODE_CHECK_CONFIG, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_item(slps_pkg::CMD_TICK, slps_pkg::MODE_IDLE, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_random_traffic(80);
        settle();

        apply_settings(16'd1, 16'd2, 4'd1, 1'b1);
        queue_random_traffic(100);
        settle();

        // Back-to-back items against a long output hold-off
        apply_settings(16'd2, 16'd3, 4'd6, 1'b0);
        queue_random_traffic(120);
        long_hold_go = 1'b1;
        settle();

        apply_settings(16'd3, 16'd1, 4'd15, 1'b1);
        queue_random_traffic(100);
        settle();

        apply_settings(16'hFFFF, 16'hFFFF, 4'd15, 1'b1);
        queue_random_traffic(60);
        settle();

        apply_settings(16'd1, 16'd0, 4'd2, 1'b1);
        queue_random_traffic(100);
        settle();

        repeat (2)
        begin
            apply_settings(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                           4'($urandom_range(0, 15)), 1'b1);
            queue_random_traffic(100);
            settle();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d items and checked %0d results over %0d register settings,",
                 items_sent, results_checked, settings_applied);
        $display("including zero and full-scale timers and one long output hold-off.");
        if (error_count == 0)
            $display("status_led_pattern_sequencer: match");
        else
            $display("status_led_pattern_sequencer: mismatch");
        $finish;
    end

endmodule

// ===== status_led_pattern_sequencer.f =====
hdl/slps_pkg.sv
hdl/slps_cfg_regs.sv
hdl/slps_core.sv
hdl/status_led_pattern_sequencer.sv
tb/tb.sv
